>>> sv/alt_pkg.sv
// ---------------------------------------------------------------------------
// alt_pkg: shared types and codes for the array list table engine
// Operation codes, status codes, sequencer states and the result word.
// ---------------------------------------------------------------------------
`default_nettype none

package alt_pkg;

  // default list capacity
  localparam int DEPTH_DEFAULT = 128;

  // fixed field widths
  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_SEARCH        = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND        = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE_LAST   = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_AT     = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH_REMOVE = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_BADPOS   = 3'd4;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_FINISH
  } state_t;

  // result word from the sequencer to the output register
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    found_index;
    logic [COUNT_W-1:0]  count;
  } result_t;

endpackage

`default_nettype wire

>>> sv/array_list_table_engine.sv
// ---------------------------------------------------------------------------
// array_list_table_engine: contiguous list of signed 32-bit values
// Search, append, remove last, remove at position and search-and-remove
// over a list held in RAM, one result word per request word.
// ---------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  ---------------------------------
//  in       in_valid / in_ready  op, value, position
//  out      out_valid/out_ready  status, found_index, count
//
//  append, remove last and unused codes need no walk; search walks the
//  list from the head, remove at position shifts down the entries above
//  the position, and search-and-remove does both, one entry a cycle over
//  the entry RAM port
//  reset clears the count and the handshakes; the entry RAM needs no clearing
//  one request is in work at a time; a finished result waits in the output
//  register while the next request word is taken
//
`default_nettype none

module array_list_table_engine #(
  parameter int DEPTH = alt_pkg::DEPTH_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic        [alt_pkg::OP_W-1:0]     op,
  input  wire logic signed [alt_pkg::VALUE_W-1:0]  value,
  input  wire logic        [alt_pkg::POS_W-1:0]    position,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic             [alt_pkg::STATUS_W-1:0] status,
  output logic             [alt_pkg::POS_W-1:0]    found_index,
  output logic             [alt_pkg::COUNT_W-1:0]  count
);

  logic             res_valid;
  logic             res_ready;
  alt_pkg::result_t res;

  // sequencer with the entry RAM
  alt_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .value    ($unsigned(value)),
    .position (position),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // output register takes a word when empty or being drained
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status      <= res.status;
      found_index <= res.found_index;
      count       <= res.count;
    end
  end

endmodule

`default_nettype wire

>>> sv/alt_ram.sv
// ---------------------------------------------------------------------------
// alt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module alt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/alt_seq.sv
// ---------------------------------------------------------------------------
// alt_seq: list sequencer
// Holds the entry count and walks the entry RAM one entry a cycle for
// linear search and for the shift-down that follows a removal.
// ---------------------------------------------------------------------------
`default_nettype none

module alt_seq #(
  parameter int DEPTH = alt_pkg::DEPTH_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [alt_pkg::OP_W-1:0]         op,
  input  wire logic [alt_pkg::VALUE_W-1:0]      value,
  input  wire logic [alt_pkg::POS_W-1:0]        position,
  output logic                                  res_valid,
  input  wire logic                             res_ready,
  output alt_pkg::result_t                      res
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > alt_pkg::POS_W) ? CW : alt_pkg::POS_W;
  localparam int YW = (CW > alt_pkg::COUNT_W) ? CW : alt_pkg::COUNT_W;
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

  alt_pkg::state_t state, state_next;

  logic [CW-1:0]                   cnt, cnt_next;
  logic [CW-1:0]                   rd_idx, rd_idx_next;
  logic [IW-1:0]                   data_idx, data_idx_next;
  logic                            data_vld, data_vld_next;
  logic [alt_pkg::OP_W-1:0]        op_q;
  logic [alt_pkg::VALUE_W-1:0]     value_q;
  logic [alt_pkg::STATUS_W-1:0]    status_q, status_next;
  logic [IW-1:0]                   found_q, found_next;

  logic                            we;
  logic [IW-1:0]                   waddr;
  logic [alt_pkg::VALUE_W-1:0]     wdata;
  logic [IW-1:0]                   raddr;
  logic [alt_pkg::VALUE_W-1:0]     rdata;

  logic                            issue;
  logic                            match;
  logic [XW-1:0]                   pos_x;
  logic [XW-1:0]                   cnt_x;
  logic [XW-1:0]                   found_x;
  logic [YW-1:0]                   cnt_y;

  // entry storage
  alt_ram #(
    .WIDTH(alt_pkg::VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // shared walk compare: more entries to read, and a hit on the word read
  assign issue = (rd_idx < cnt);
  assign match = (rdata == value_q);
  assign pos_x = XW'(position);
  assign cnt_x = XW'(cnt);

  // state and walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= alt_pkg::ST_IDLE;
      cnt      <= '0;
      data_vld <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      data_vld <= data_vld_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx   <= rd_idx_next;
    data_idx <= data_idx_next;
    status_q <= status_next;
    found_q  <= found_next;
    if (in_valid && in_ready) begin
      op_q    <= op;
      value_q <= value;
    end
  end

  // next state, RAM control and handshakes
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    rd_idx_next   = rd_idx;
    data_idx_next = rd_idx[IW-1:0];
    data_vld_next = 1'b0;
    status_next   = status_q;
    found_next    = found_q;
    we            = 1'b0;
    waddr         = cnt[IW-1:0];
    wdata         = value;
    raddr         = rd_idx[IW-1:0];
    in_ready      = 1'b0;
    res_valid     = 1'b0;

    unique case (state)
      alt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          status_next = alt_pkg::STAT_OK;
          found_next  = '0;
          state_next  = alt_pkg::ST_FINISH;
          unique case (op)
            alt_pkg::OP_SEARCH, alt_pkg::OP_SEARCH_REMOVE: begin
              if (cnt == '0) begin
                status_next = alt_pkg::STAT_NOTFOUND;
              end else begin
                rd_idx_next = '0;
                state_next  = alt_pkg::ST_SEARCH;
              end
            end
            alt_pkg::OP_APPEND: begin
              if (cnt < CNT_MAX) begin
                we       = 1'b1;
                cnt_next = cnt + CW'(1);
              end else begin
                status_next = alt_pkg::STAT_FULL;
              end
            end
            alt_pkg::OP_REMOVE_LAST: begin
              if (cnt != '0) begin
                cnt_next = cnt - CW'(1);
              end else begin
                status_next = alt_pkg::STAT_EMPTY;
              end
            end
            alt_pkg::OP_REMOVE_AT: begin
              if (cnt == '0) begin
                status_next = alt_pkg::STAT_EMPTY;
              end else if (pos_x >= cnt_x) begin
                status_next = alt_pkg::STAT_BADPOS;
              end else begin
                rd_idx_next = CW'(position) + CW'(1);
                state_next  = alt_pkg::ST_SHIFT;
              end
            end
            default: begin
              // unused codes report ok with no change
            end
          endcase
        end
      end

      alt_pkg::ST_SEARCH: begin
        // read one entry ahead, compare the word read last cycle
        if (issue) begin
          rd_idx_next   = rd_idx + CW'(1);
          data_vld_next = 1'b1;
        end
        if (data_vld && match) begin
          found_next = data_idx;
          if (op_q == alt_pkg::OP_SEARCH_REMOVE) begin
            rd_idx_next   = CW'(data_idx) + CW'(1);
            data_vld_next = 1'b0;
            state_next    = alt_pkg::ST_SHIFT;
          end else begin
            state_next = alt_pkg::ST_FINISH;
          end
        end else if (data_vld && (CW'(data_idx) + CW'(1) == cnt)) begin
          status_next = alt_pkg::STAT_NOTFOUND;
          state_next  = alt_pkg::ST_FINISH;
        end
      end

      alt_pkg::ST_SHIFT: begin
        // read entry j+1 and write it to j on the next cycle
        if (issue) begin
          rd_idx_next   = rd_idx + CW'(1);
          data_vld_next = 1'b1;
        end
        if (data_vld) begin
          we    = 1'b1;
          waddr = data_idx - IW'(1);
          wdata = rdata;
        end
        if (!issue && !data_vld) begin
          cnt_next   = cnt - CW'(1);
          state_next = alt_pkg::ST_FINISH;
        end
      end

      alt_pkg::ST_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = alt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = alt_pkg::ST_IDLE;
      end
    endcase
  end

  // result word
  assign found_x         = XW'(found_q);
  assign cnt_y           = YW'(cnt);
  assign res.status      = status_q;
  assign res.found_index = found_x[alt_pkg::POS_W-1:0];
  assign res.count       = cnt_y[alt_pkg::COUNT_W-1:0];

  // count never passes capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_MAX)
    else $error("entry count above capacity");

  // RAM is written only by append or by the shift-down
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == alt_pkg::ST_IDLE || state == alt_pkg::ST_SHIFT))
    else $error("RAM write outside append or shift");

  // search read pointer stays within the list
  a_search_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == alt_pkg::ST_SEARCH) |-> (rd_idx <= cnt))
    else $error("search pointer past count");

  // a finished shift-down drops the count by one
  a_shift_dec: assert property (@(posedge clk) disable iff (rst)
    (state == alt_pkg::ST_SHIFT && state_next == alt_pkg::ST_FINISH)
      |=> (cnt == $past(cnt) - CW'(1)))
    else $error("shift did not shrink count");

endmodule

`default_nettype wire

>>> bench/tb_array_list_table_engine.sv
// ---------------------------------------------------------------------------
// tb_array_list_table_engine: self-checking bench for the array list engine
// Drives request words (directed corner cases, then random fill, drain and
// mixed traffic) and checks every result word against an in-bench list model.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_array_list_table_engine;

  localparam int DEPTH        = alt_pkg::DEPTH_DEFAULT;
  localparam int OP_W         = alt_pkg::OP_W;
  localparam int VALUE_W      = alt_pkg::VALUE_W;
  localparam int POS_W        = alt_pkg::POS_W;
  localparam int STATUS_W     = alt_pkg::STATUS_W;
  localparam int COUNT_W      = alt_pkg::COUNT_W;
  localparam int N_RANDOM     = 1280;
  localparam int TOTAL_WORDS  = N_RANDOM + 24;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = DEPTH + 40;
  localparam int POOL_SIZE    = 12;

  // op codes with no defined operation
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  // idle schemes for the two channels
  localparam logic [1:0] MODE_RECV_SLOW = 2'd0;
  localparam logic [1:0] MODE_SEND_SLOW = 2'd1;
  localparam logic [1:0] MODE_FULL_RATE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
    logic                      hold;
    logic [1:0]                idle_mode;
  } request_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [OP_W-1:0]            op = '0;
  logic signed [VALUE_W-1:0]  value = '0;
  logic [POS_W-1:0]           position = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [STATUS_W-1:0]        status;
  logic [POS_W-1:0]           found_index;
  logic [COUNT_W-1:0]         count;

  request_t         request_q[$];
  alt_pkg::result_t expected_results[$];

  // list model
  logic [VALUE_W-1:0] list_mem [DEPTH];
  int                 list_len = 0;

  logic [VALUE_W-1:0] value_pool [POOL_SIZE];
  logic [1:0]         idle_mode = MODE_RECV_SLOW;
  int                 words_sent = 0;
  int                 results_seen = 0;
  int                 idle_cycles = 0;
  int                 n_fail = 0;

  wire [6:0] send_idle_pct = (idle_mode == MODE_RECV_SLOW) ? 7'd6 :
                             (idle_mode == MODE_SEND_SLOW) ? 7'd48 : 7'd0;
  wire [6:0] recv_idle_pct = (idle_mode == MODE_RECV_SLOW) ? 7'd48 :
                             (idle_mode == MODE_SEND_SLOW) ? 7'd6 : 7'd0;

  array_list_table_engine #(.DEPTH(DEPTH)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .value       (value),
    .position    (position),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found_index (found_index),
    .count       (count)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one request to the list model and return the result word
  function automatic alt_pkg::result_t apply_list_request(input logic [OP_W-1:0] code,
                                                          input logic [VALUE_W-1:0] v,
                                                          input logic [POS_W-1:0] pos);
    alt_pkg::result_t r;
    int               hit;
    int               cut;
    r.status      = alt_pkg::STAT_OK;
    r.found_index = '0;
    hit = -1;
    cut = -1;
    case (code)
      alt_pkg::OP_SEARCH, alt_pkg::OP_SEARCH_REMOVE: begin
        // walk down so the lowest match wins
        for (int i = list_len - 1; i >= 0; i--)
          if (list_mem[i] == v) hit = i;
        if (hit < 0) begin
          r.status = alt_pkg::STAT_NOTFOUND;
        end else begin
          r.found_index = hit[POS_W-1:0];
          if (code == alt_pkg::OP_SEARCH_REMOVE) cut = hit;
        end
      end
      alt_pkg::OP_APPEND: begin
        if (list_len < DEPTH) begin
          list_mem[list_len] = v;
          list_len++;
        end else begin
          r.status = alt_pkg::STAT_FULL;
        end
      end
      alt_pkg::OP_REMOVE_LAST: begin
        if (list_len > 0) list_len--;
        else r.status = alt_pkg::STAT_EMPTY;
      end
      alt_pkg::OP_REMOVE_AT: begin
        if (list_len == 0) r.status = alt_pkg::STAT_EMPTY;
        else if (int'(pos) >= list_len) r.status = alt_pkg::STAT_BADPOS;
        else cut = int'(pos);
      end
      default: ;
    endcase
    // close the gap left by a deleted entry
    if (cut >= 0) begin
      for (int j = cut; j < list_len - 1; j++)
        list_mem[j] = list_mem[j + 1];
      list_len--;
    end
    r.count = list_len[COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 75) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 99) < 60) return POS_W'($urandom_range(0, 40));
    return POS_W'($urandom_range(0, 127));
  endfunction

  // push one request word; idle scheme follows the position in the run
  task automatic queue_word(input logic [OP_W-1:0] code, input logic [VALUE_W-1:0] v,
                            input logic [POS_W-1:0] pos, input logic hold);
    request_t w;
    w.op       = code;
    w.value    = v;
    w.position = pos;
    w.hold     = hold;
    if (request_q.size() < TOTAL_WORDS / 3) w.idle_mode = MODE_RECV_SLOW;
    else if (request_q.size() < 2 * TOTAL_WORDS / 3) w.idle_mode = MODE_SEND_SLOW;
    else w.idle_mode = MODE_FULL_RATE;
    request_q.push_back(w);
  endtask

  // stimulus
  initial begin : stimulus
    int generated;
    int episode;
    int kind;
    int len;
    int r;
    logic [OP_W-1:0] code;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    // empty list corner cases and spare codes
    queue_word(alt_pkg::OP_SEARCH, 32'h0000_0000, 7'd0, 1'b0);
    queue_word(alt_pkg::OP_SEARCH_REMOVE, 32'hffff_ffff, 7'd0, 1'b0);
    queue_word(alt_pkg::OP_REMOVE_LAST, 32'h0000_0000, 7'd0, 1'b0);
    queue_word(alt_pkg::OP_REMOVE_AT, 32'h0000_0000, 7'd0, 1'b0);
    queue_word(OP_SPARE_A, 32'h1234_5678, 7'd127, 1'b0);
    queue_word(OP_SPARE_B, 32'h0000_0000, 7'd0, 1'b0);
    queue_word(OP_SPARE_C, 32'hffff_ffff, 7'd127, 1'b0);
    // extremes of the value field, with a duplicate
    queue_word(alt_pkg::OP_APPEND, 32'h8000_0000, 7'd0, 1'b0);
    queue_word(alt_pkg::OP_APPEND, 32'h7fff_ffff, 7'd0, 1'b0);
    queue_word(alt_pkg::OP_APPEND, 32'h0000_0000, 7'd0, 1'b0);
    queue_word(alt_pkg::OP_APPEND, 32'hffff_ffff, 7'd0, 1'b0);
    queue_word(alt_pkg::OP_APPEND, 32'h7fff_ffff, 7'd0, 1'b0);
    queue_word(alt_pkg::OP_SEARCH, 32'h7fff_ffff, 7'd0, 1'b0);
    queue_word(alt_pkg::OP_SEARCH, 32'hffff_ffff, 7'd0, 1'b0);
    // position past the end, far and near
    queue_word(alt_pkg::OP_REMOVE_AT, 32'h0000_0000, 7'd127, 1'b0);
    queue_word(alt_pkg::OP_REMOVE_AT, 32'h0000_0000, 7'd5, 1'b0);
    // search-and-remove takes the first match, the second one moves down
    queue_word(alt_pkg::OP_SEARCH_REMOVE, 32'h7fff_ffff, 7'd0, 1'b0);
    queue_word(alt_pkg::OP_SEARCH, 32'h7fff_ffff, 7'd0, 1'b0);
    queue_word(alt_pkg::OP_REMOVE_AT, 32'h0000_0000, 7'd0, 1'b0);
    queue_word(alt_pkg::OP_REMOVE_LAST, 32'h0000_0000, 7'd0, 1'b0);
    queue_word(alt_pkg::OP_SEARCH, 32'h0001_2345, 7'd0, 1'b0);
    queue_word(alt_pkg::OP_SEARCH_REMOVE, 32'h0000_0000, 7'd0, 1'b0);

    // random episodes: fill, drain and mixed traffic
    generated = 0;
    episode = 0;
    while (generated < N_RANDOM) begin
      if (episode == 0) kind = 0;
      else if (episode == 1) kind = 1;
      else kind = $urandom_range(0, 9);
      case (kind)
        0, 2: begin
          // fill; a long burst always reaches full
          len = (kind == 0 || $urandom_range(0, 3) == 0) ? DEPTH + 7 : $urandom_range(4, 20);
          for (int i = 0; i < len; i++)
            queue_word(alt_pkg::OP_APPEND, pick_value(), POS_W'($urandom_range(0, 127)),
                       (i == 0) && (episode == 0 || $urandom_range(0, 7) == 0));
        end
        1, 3: begin
          // drain; a long burst always empties the list
          if (kind == 1 || $urandom_range(0, 3) == 0) begin
            len = DEPTH + 7;
            for (int i = 0; i < len; i++)
              queue_word(alt_pkg::OP_REMOVE_LAST, pick_value(), pick_position(), 1'b0);
            queue_word(alt_pkg::OP_SEARCH, pick_value(), pick_position(), 1'b0);
            queue_word(alt_pkg::OP_SEARCH_REMOVE, pick_value(), pick_position(), 1'b0);
            queue_word(alt_pkg::OP_REMOVE_AT, pick_value(), pick_position(), 1'b0);
            len += 3;
          end else begin
            len = $urandom_range(4, 20);
            for (int i = 0; i < len; i++) begin
              r = $urandom_range(0, 2);
              code = (r == 0) ? alt_pkg::OP_REMOVE_LAST :
                     (r == 1) ? alt_pkg::OP_REMOVE_AT : alt_pkg::OP_SEARCH_REMOVE;
              queue_word(code, pick_value(), pick_position(),
                         (i == 0) && ($urandom_range(0, 7) == 0));
            end
          end
        end
        default: begin
          len = $urandom_range(10, 30);
          for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 25) code = alt_pkg::OP_SEARCH;
            else if (r < 50) code = alt_pkg::OP_APPEND;
            else if (r < 62) code = alt_pkg::OP_REMOVE_LAST;
            else if (r < 75) code = alt_pkg::OP_REMOVE_AT;
            else if (r < 96) code = alt_pkg::OP_SEARCH_REMOVE;
            else code = OP_SPARE_A + OP_W'($urandom_range(0, 2));
            queue_word(code, pick_value(), pick_position(),
                       (i == 0) && ($urandom_range(0, 7) == 0));
          end
        end
      endcase
      generated += len;
      episode++;
    end
  end

  // reset and end of run
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (request_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // driver: request words from the queue, random idles on both channels
  always @(posedge clk) begin : driver
    request_t nxt;
    logic     drained;
    drained = (words_sent == results_seen) && !(in_valid && in_ready) &&
              !(out_valid && out_ready);
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!in_valid || in_ready) begin
        if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
            (!request_q[0].hold || drained)) begin
          nxt = request_q.pop_front();
          in_valid  <= 1'b1;
          op        <= nxt.op;
          value     <= nxt.value;
          position  <= nxt.position;
          idle_mode <= nxt.idle_mode;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check result words, then predict for accepted request words
  always @(posedge clk) begin : monitor
    alt_pkg::result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: status %0d index %0d count %0d",
                 status, found_index, count);
          n_fail++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            n_fail++;
          end
          if (found_index !== want.found_index) begin
            $error("found_index: expected %0d, got %0d", want.found_index, found_index);
            n_fail++;
          end
          if (count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, count);
            n_fail++;
          end
        end
      end
      if (in_valid && in_ready) begin
        words_sent <= words_sent + 1;
        expected_results.push_back(apply_list_request(op, value, position));
      end
      // watchdog on cycles with no word moving
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

`default_nettype wire
